// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file sil_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sil_pkg.sv =====
package sil_pkg;

  typedef enum logic {
    JOB_PAIR,
    JOB_PASS
  } job_kind_t;

  // Control part of one back-end job; sample data travels beside it.
  typedef struct packed {
    job_kind_t kind;
    logic      left_self;
    logic      line_end;
  } job_ctl_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ABS,
    BK_DIV,
    BK_SUM,
    BK_LIM,
    BK_CLAMP,
    BK_RES,
    BK_FIRST,
    BK_SECOND,
    BK_PASS
  } back_state_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== hdl/sil_front.sv =====
module sil_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic        [SAMPLE_BITS-1:0] avg_value,
  input  logic        [SAMPLE_BITS-1:0] residual_value,
  input  logic                          has_residual,
  input  logic                          last_in_line,
  output logic                          push_valid,
  output sil_pkg::job_ctl_t             push_ctl,
  output logic        [SAMPLE_BITS-1:0] push_avg,
  output logic        [SAMPLE_BITS-1:0] push_nxt,
  output logic        [SAMPLE_BITS-1:0] push_res,
  input  logic                          q_full
);

  logic                   started;
  logic                   held_first;
  logic [SAMPLE_BITS-1:0] held_avg;
  logic [SAMPLE_BITS-1:0] held_res;

  // second job of a closing word waits here for a free queue slot
  logic                   pend_valid;
  sil_pkg::job_ctl_t      pend_ctl;
  logic [SAMPLE_BITS-1:0] pend_avg;
  logic [SAMPLE_BITS-1:0] pend_res;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] res_in;
  sil_pkg::job_ctl_t      pair_ctl;
  sil_pkg::job_ctl_t      tail_ctl;

  assign in_ready = !pend_valid && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    res_in = has_residual ? residual_value : '0;
    pair_ctl = '{kind: sil_pkg::JOB_PAIR, left_self: held_first, line_end: 1'b0};
    tail_ctl = '{kind: has_residual ? sil_pkg::JOB_PAIR : sil_pkg::JOB_PASS,
                 left_self: !started, line_end: 1'b1};

    push_valid = 1'b0;
    push_ctl   = pend_ctl;
    push_avg   = pend_avg;
    push_nxt   = pend_avg;
    push_res   = pend_res;
    if (pend_valid) begin
      push_valid = 1'b1;
    end else if (accept) begin
      if (started) begin
        push_valid = 1'b1;
        push_ctl   = pair_ctl;
        push_avg   = held_avg;
        push_nxt   = avg_value;
        push_res   = held_res;
      end else if (last_in_line) begin
        push_valid = 1'b1;
        push_ctl   = tail_ctl;
        push_avg   = avg_value;
        push_nxt   = avg_value;
        push_res   = res_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (started && last_in_line) begin
          pend_valid <= 1'b1;
        end
        started <= !last_in_line;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ctl   <= tail_ctl;
      pend_avg   <= avg_value;
      pend_res   <= res_in;
      held_first <= !started;
      held_avg   <= avg_value;
      held_res   <= res_in;
    end
  end

endmodule

// ===== hdl/sil_queue.sv =====
module sil_queue #(
  parameter int DATA_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  sil_pkg::job_ctl_t    push_ctl,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output sil_pkg::job_ctl_t    head_ctl,
  output logic [DATA_BITS-1:0] head_data
);

  sil_pkg::job_ctl_t                ctl_q  [sil_pkg::QUEUE_DEPTH];
  logic [DATA_BITS-1:0]             data_q [sil_pkg::QUEUE_DEPTH];
  logic [sil_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [sil_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [sil_pkg::QCNT_BITS-1:0]    count;
  logic                             do_push;
  logic                             do_pop;

  assign full      = (count == sil_pkg::QCNT_BITS'(sil_pkg::QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && !empty;
  assign head_ctl  = ctl_q[rd_ptr];
  assign head_data = data_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_q[wr_ptr]  <= push_ctl;
      data_q[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/sil_back.sv =====
module sil_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  output logic                   pop,
  input  sil_pkg::job_ctl_t      head_ctl,
  input  logic [SAMPLE_BITS-1:0] head_avg,
  input  logic [SAMPLE_BITS-1:0] head_nxt,
  input  logic [SAMPLE_BITS-1:0] head_res,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] pixel_value,
  output logic                   line_end
);

  localparam int N = SAMPLE_BITS;
  // floor(x/3) for 0 <= x < 2^(N-1): (x * ceil(2^(N+1)/3)) >> (N+1)
  localparam logic [63:0]  RECIP_W     = ((64'd1 << (N + 1)) + 64'd2) / 64'd3;
  localparam logic [N-1:0] RECIP       = RECIP_W[N-1:0];
  // floor(-2^(N-1) / 3), the one negative magnitude a wrapped abs can give
  localparam logic [63:0]  NEG_THIRD_W = 64'd0 - (((64'd1 << (N - 1)) + 64'd2) / 64'd3);
  localparam logic [N-1:0] NEG_THIRD   = NEG_THIRD_W[N-1:0];

  sil_pkg::back_state_t state, state_next;

  sil_pkg::job_ctl_t job_ctl;
  logic [N-1:0]      job_avg;
  logic [N-1:0]      job_nxt;
  logic [N-1:0]      job_res;
  logic [N-1:0]      left;
  logic [N-1:0]      aab;
  logic [N-1:0]      abc;
  logic [N-1:0]      aac;
  logic              zero_t;
  logic              neg_t;
  logic [N-1:0]      quot;
  logic [N-1:0]      aac_p2;
  logic [N-1:0]      x;
  logic [N-1:0]      diff;
  logic [N-1:0]      first;

  logic              out_free;
  logic              out_load;
  logic [N-1:0]      out_pix_next;
  logic              out_end_next;
  logic              can_pop;
  logic [N-1:0]      a_val;
  logic [N-1:0]      ab, ba, bc, cb, ac, ca;
  logic [2*N-2:0]    prod;
  logic [N-1:0]      quot_next;
  logic [N-1:0]      sum_w;
  logic [N-1:0]      lim;
  logic [N-1:0]      x_lim;
  logic [N-1:0]      x_round;
  logic [N-1:0]      bc2;
  logic [N-1:0]      x_clamp;
  logic [N-1:0]      diff_next;
  logic [N-1:0]      first_next;
  logic [N-1:0]      second;

  always_comb begin
    a_val = job_ctl.left_self ? job_avg : left;
    ab = a_val - job_avg;
    ba = job_avg - a_val;
    bc = job_avg - job_nxt;
    cb = job_nxt - job_avg;
    ac = a_val - job_nxt;
    ca = job_nxt - a_val;

    prod = {{N{1'b0}}, aab[N-2:0]} * {{(N-1){1'b0}}, RECIP};
    quot_next = aab[N-1] ? NEG_THIRD : {2'b00, prod[2*N-2:N+1]};

    sum_w = quot + aac_p2;
    lim   = {aab[N-2:0], 1'b0} + {{(N-1){1'b0}}, x[0]};
    x_lim = ($signed(x) > $signed(lim)) ? {aab[N-2:0], 1'b1} : x;

    x_round = x + {{(N-1){1'b0}}, x[0]};
    bc2     = {abc[N-2:0], 1'b0};
    x_clamp = ($signed(x_round) > $signed(bc2)) ? bc2 : x;

    diff_next  = zero_t ? job_res : (neg_t ? job_res - x : job_res + x);
    // avg + diff/2 with the halving truncated toward zero
    first_next = job_avg + {diff[N-1], diff[N-1:1]}
                 + {{(N-1){1'b0}}, diff[N-1] & diff[0]};
    second     = first - diff;
  end

  always_comb begin
    out_free     = !out_valid || out_ready;
    can_pop      = !q_empty && ((state == sil_pkg::BK_IDLE) ||
                   (((state == sil_pkg::BK_SECOND) || (state == sil_pkg::BK_PASS))
                    && out_free));
    pop          = can_pop;
    out_load     = 1'b0;
    out_pix_next = first_next;
    out_end_next = 1'b0;
    state_next   = state;

    unique case (state)
      sil_pkg::BK_IDLE: begin
        if (can_pop) begin
          state_next = (head_ctl.kind == sil_pkg::JOB_PASS) ? sil_pkg::BK_PASS
                                                             : sil_pkg::BK_ABS;
        end
      end
      sil_pkg::BK_ABS:   state_next = sil_pkg::BK_DIV;
      sil_pkg::BK_DIV:   state_next = sil_pkg::BK_SUM;
      sil_pkg::BK_SUM:   state_next = sil_pkg::BK_LIM;
      sil_pkg::BK_LIM:   state_next = sil_pkg::BK_CLAMP;
      sil_pkg::BK_CLAMP: state_next = sil_pkg::BK_RES;
      sil_pkg::BK_RES:   state_next = sil_pkg::BK_FIRST;
      sil_pkg::BK_FIRST: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = sil_pkg::BK_SECOND;
        end
      end
      sil_pkg::BK_SECOND, sil_pkg::BK_PASS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_pix_next = (state == sil_pkg::BK_PASS) ? job_avg : second;
          out_end_next = job_ctl.line_end;
          if (can_pop) begin
            state_next = (head_ctl.kind == sil_pkg::JOB_PASS) ? sil_pkg::BK_PASS
                                                               : sil_pkg::BK_ABS;
          end else begin
            state_next = sil_pkg::BK_IDLE;
          end
        end
      end
      default: state_next = sil_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sil_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_pop) begin
      job_ctl <= head_ctl;
      job_avg <= head_avg;
      job_nxt <= head_nxt;
      job_res <= head_res;
    end
    if (out_load) begin
      pixel_value <= out_pix_next;
      line_end    <= out_end_next;
    end
    case (state)
      sil_pkg::BK_ABS: begin
        aab    <= ab[N-1] ? ba : ab;
        abc    <= bc[N-1] ? cb : bc;
        aac    <= ac[N-1] ? ca : ac;
        zero_t <= (ab != '0) && (bc != '0) && (ab[N-1] != bc[N-1]);
        neg_t  <= $signed(job_nxt) > $signed(a_val);
      end
      sil_pkg::BK_DIV: begin
        quot   <= quot_next;
        aac_p2 <= aac + N'(2);
      end
      sil_pkg::BK_SUM:   x <= $signed(sum_w) >>> 2;
      sil_pkg::BK_LIM:   x <= x_lim;
      sil_pkg::BK_CLAMP: x <= x_clamp;
      sil_pkg::BK_RES:   diff <= diff_next;
      sil_pkg::BK_FIRST: begin
        if (out_free) begin
          first <= first_next;
        end
      end
      sil_pkg::BK_SECOND: begin
        if (out_free) begin
          left <= second;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/squeeze_inverse_line_core.sv =====
// Inverse squeeze of one image line (row or column).
// Input channel (in_valid/in_ready): one word per average sample, with its
// residual, has_residual and last_in_line. Output channel (out_valid/
// out_ready): reconstructed samples in line order, line_end on the last one.
// A word is held until the next average arrives; then its pair is made.
// The closing word of a line releases the held pair plus its own pair, or
// its own average unchanged when it carries no residual.
// Front end takes words and queues jobs (4 deep); back end computes them.
// A pair job steps the back end through ABS, DIV, SUM, LIM, CLAMP, RES,
// FIRST and SECOND, one job at a time as the left-neighbor recurrence
// (the second sample of one pair feeds the tendency of the next) demands;
// a pass-through job takes the PASS state alone. The next job is popped as
// the last sample of the current one is loaded into the output register.
// in_ready drops while the job queue is full or a second job is pending.
// A stalled receiver holds the output register; the back end then waits,
// the queue fills and in_ready falls, with no sample lost.
// Synchronous reset empties the queue, drops any held word and clears
// out_valid; the first word after reset starts a new line.
module squeeze_inverse_line_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] avg_value,
  input  logic signed [SAMPLE_BITS-1:0] residual_value,
  input  logic                          has_residual,
  input  logic                          last_in_line,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] pixel_value,
  output logic                          line_end
);

  localparam int N = SAMPLE_BITS;

  logic              push_valid;
  sil_pkg::job_ctl_t push_ctl;
  logic [N-1:0]      push_avg;
  logic [N-1:0]      push_nxt;
  logic [N-1:0]      push_res;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  sil_pkg::job_ctl_t head_ctl;
  logic [3*N-1:0]    head_data;
  logic [N-1:0]      pix;

  sil_front #(.SAMPLE_BITS(N)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .avg_value      (avg_value),
    .residual_value (residual_value),
    .has_residual   (has_residual),
    .last_in_line   (last_in_line),
    .push_valid     (push_valid),
    .push_ctl       (push_ctl),
    .push_avg       (push_avg),
    .push_nxt       (push_nxt),
    .push_res       (push_res),
    .q_full         (q_full)
  );

  sil_queue #(.DATA_BITS(3 * N)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ctl   (push_ctl),
    .push_data  ({push_avg, push_nxt, push_res}),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head_ctl   (head_ctl),
    .head_data  (head_data)
  );

  sil_back #(.SAMPLE_BITS(N)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .pop         (pop),
    .head_ctl    (head_ctl),
    .head_avg    (head_data[3*N-1:2*N]),
    .head_nxt    (head_data[2*N-1:N]),
    .head_res    (head_data[N-1:0]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pix),
    .line_end    (line_end)
  );

  assign pixel_value = $signed(pix);

endmodule

// ===== hdl/sil_checker.sv =====
`include "assert_macros.svh"

module sil_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          has_residual,
  input logic                          last_in_line,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] pixel_value,
  input logic                          line_end
);

  // samples owed: two per word, one for a closing word without residual
  logic [5:0]             owed;
  logic [5:0]             owed_next;
  logic [5:0]             lines;
  logic [5:0]             lines_next;
  logic                   in_acc;
  logic                   out_acc;
  logic                   out_stall;
  logic [SAMPLE_BITS:0]   out_word;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {pixel_value, line_end};

  always_comb begin
    owed_next  = owed;
    lines_next = lines;
    if (in_acc) begin
      owed_next  = owed_next + ((has_residual || !last_in_line) ? 6'd2 : 6'd1);
      lines_next = lines_next + {5'd0, last_in_line};
    end
    if (out_acc) begin
      owed_next  = owed_next - 6'd1;
      lines_next = lines_next - {5'd0, line_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owed  <= '0;
      lines <= '0;
    end else begin
      owed  <= owed_next;
      lines <= lines_next;
    end
  end

  `ASSERT_NEXT_ANY(a_reset_quiet, clk, rst, !out_valid, "output valid after reset")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_word), "stalled word changed")
  `ASSERT_IMPLY(a_no_extra, clk, rst, out_acc, owed != 6'd0, "unowed sample")
  `ASSERT_IMPLY(a_line_end_owed, clk, rst, out_acc && line_end, lines != 6'd0, "unowed line end")

endmodule

bind squeeze_inverse_line_core sil_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sil_checker (.*);
